/* rtl/core/hhft_pkg.sv */
// Shared definitions for the HTTP header field tokenizer.
// Phase codes, event codes, delimiter bytes, the max_value_len reset value and the step control struct.
// No dependencies.
package hhft_pkg;

    // Parse phases
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_KEY   = 4'd1;
    localparam logic [3:0] PH_COLON = 4'd2;
    localparam logic [3:0] PH_SPACE = 4'd3;
    localparam logic [3:0] PH_VALUE = 4'd4;
    localparam logic [3:0] PH_CR    = 4'd5;
    localparam logic [3:0] PH_LF    = 4'd6;
    localparam logic [3:0] PH_ENDCR = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;
    localparam logic [3:0] PH_ERROR = 4'd9;

    // Result event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_PAIR  = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // Delimiter bytes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Value of max_value_len after reset
    localparam logic [15:0] MAX_VALUE_LEN_RST = 16'd255;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] ev;
    } hhft_ctl_t;

endpackage

/* rtl/core/http_header_field_tokenizer.sv */
// HTTP header field tokenizer, top level: stream ports, input and result stages.
// Depends on hhft_pkg and hhft_step.
//
// Feed the bytes of an HTTP header block, one per beat, on the slave stream; set
// tuser on the first byte of each block to clear the parser and restart the offset
// count at zero. Every input beat yields exactly one result beat on the master
// stream, carrying an event in tuser (none, header pair complete, block done, error)
// and, on a pair event, the key and value start offsets and lengths in tdata (zero
// on all other events). The block sustains one byte per clock while the master side
// does not stall: the phase machine and offset registers close their loop through a
// single pass of the step logic; the input register loads at acceptance and the
// result register loads from it once the result stage is free. The input stage can
// take a byte while a finished result still waits on the master side, but only while
// it holds no byte of its own. Done and error stick until a byte with tuser set
// arrives. The user writes max_value_len through cfg_wr_en / cfg_wr_data only while
// the stream is idle, which the block itself does not enforce; it resets to 255.
// OFFSET_BITS sizes the internal offset counter (8 to 32); bytes past 2^OFFSET_BITS-1
// flag an offset overflow error, and reported offsets keep their low 16 bits.
module http_header_field_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_value_len
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] hdr_byte
    input  logic [0:0]  s_axis_tuser,   // [0] new_block
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] key_pos, [31:16] key_len,
                                        // [47:32] value_pos, [63:48] value_len
    output logic [1:0]  m_axis_tuser    // [1:0] event_res
);
    import hhft_pkg::*;

    // configuration register
    logic [15:0]            max_len_reg;

    // input stage
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_nb_reg;

    // parser state
    logic [3:0]             phase_reg;
    logic [OFFSET_BITS:0]   offset_reg;
    logic [OFFSET_BITS-1:0] key_begin_reg;
    logic [OFFSET_BITS-1:0] key_finish_reg;
    logic [OFFSET_BITS-1:0] value_begin_reg;
    logic [OFFSET_BITS-1:0] value_finish_reg;

    // result stage
    logic                   out_valid_reg;
    logic [1:0]             out_ev_reg;
    logic [63:0]            out_data_reg;

    // step results
    hhft_ctl_t              step_ctl;
    logic [OFFSET_BITS:0]   offset_next;
    logic [OFFSET_BITS-1:0] key_begin_next;
    logic [OFFSET_BITS-1:0] key_finish_next;
    logic [OFFSET_BITS-1:0] value_begin_next;
    logic [OFFSET_BITS-1:0] value_finish_next;
    logic [15:0]            key_pos;
    logic [15:0]            key_len;
    logic [15:0]            value_pos;
    logic [15:0]            value_len;

    logic                   out_free;
    logic                   proc;

    // Result stage takes a new beat when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // Parse the held byte whenever its result has somewhere to go
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ev_reg;
    assign m_axis_tdata  = out_data_reg;

    hhft_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .phase             (phase_reg),
        .offset            (offset_reg),
        .key_begin         (key_begin_reg),
        .key_finish        (key_finish_reg),
        .value_begin       (value_begin_reg),
        .value_finish      (value_finish_reg),
        .hdr_byte          (in_byte_reg),
        .new_block         (in_nb_reg),
        .max_value_len     (max_len_reg),
        .ctl               (step_ctl),
        .offset_next       (offset_next),
        .key_begin_next    (key_begin_next),
        .key_finish_next   (key_finish_next),
        .value_begin_next  (value_begin_next),
        .value_finish_next (value_finish_next),
        .key_pos           (key_pos),
        .key_len           (key_len),
        .value_pos         (value_pos),
        .value_len         (value_len)
    );

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_VALUE_LEN_RST;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    // Input stage: load a beat whenever the stage is free to take one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_nb_reg   <= s_axis_tuser[0];
        end
    end

    // Parser state: advance once per parsed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            offset_reg       <= '0;
            key_begin_reg    <= '0;
            key_finish_reg   <= '0;
            value_begin_reg  <= '0;
            value_finish_reg <= '0;
        end
        else if (proc)
        begin
            phase_reg        <= step_ctl.phase;
            offset_reg       <= offset_next;
            key_begin_reg    <= key_begin_next;
            key_finish_reg   <= key_finish_next;
            value_begin_reg  <= value_begin_next;
            value_finish_reg <= value_finish_next;
        end
    end

    // Result stage: hold while the master side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_ev_reg   <= step_ctl.ev;
            out_data_reg <= {value_len, value_pos, key_len, key_pos};
        end
    end

    // Position fields are zero on every event but a completed pair
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ev_reg != EV_PAIR) |-> (out_data_reg == 64'd0))
        else $error("nonzero position fields on a non-pair event");

    // Done and error hold until a byte opens a new block
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && !in_nb_reg && (phase_reg == PH_DONE || phase_reg == PH_ERROR))
        |=> $stable(phase_reg))
        else $error("sticky phase left without a new block");

    // A pair completes only on LF after a value's CR within the same block
    a_pair_src: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && step_ctl.ev == EV_PAIR)
        |-> (phase_reg == PH_CR && in_byte_reg == CH_LF && !in_nb_reg))
        else $error("pair event from wrong phase");

    // Error event always lands in the error phase
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && step_ctl.ev == EV_ERROR) |=> (phase_reg == PH_ERROR))
        else $error("error event without error phase");

    // Offset counter saturates at 2^OFFSET_BITS
    a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !(offset_reg[OFFSET_BITS] && (offset_reg[OFFSET_BITS-1:0] != '0)))
        else $error("offset counter past saturation");

endmodule

/* rtl/core/hhft_step.sv */
// Next-state and result logic for one header byte.
// Depends on hhft_pkg.
module hhft_step #(
    parameter int OFFSET_BITS = 16
) (
    input  logic [3:0]             phase,
    input  logic [OFFSET_BITS:0]   offset,
    input  logic [OFFSET_BITS-1:0] key_begin,
    input  logic [OFFSET_BITS-1:0] key_finish,
    input  logic [OFFSET_BITS-1:0] value_begin,
    input  logic [OFFSET_BITS-1:0] value_finish,
    input  logic [7:0]             hdr_byte,
    input  logic                   new_block,
    input  logic [15:0]            max_value_len,
    output hhft_pkg::hhft_ctl_t    ctl,
    output logic [OFFSET_BITS:0]   offset_next,
    output logic [OFFSET_BITS-1:0] key_begin_next,
    output logic [OFFSET_BITS-1:0] key_finish_next,
    output logic [OFFSET_BITS-1:0] value_begin_next,
    output logic [OFFSET_BITS-1:0] value_finish_next,
    output logic [15:0]            key_pos,
    output logic [15:0]            key_len,
    output logic [15:0]            value_pos,
    output logic [15:0]            value_len
);
    import hhft_pkg::*;

    localparam int WIDE = OFFSET_BITS + 16;

    logic [3:0]             ph;
    logic [OFFSET_BITS:0]   off;
    logic [OFFSET_BITS-1:0] off_lo;
    logic [OFFSET_BITS-1:0] kb;
    logic [OFFSET_BITS-1:0] kf;
    logic [OFFSET_BITS-1:0] vb;
    logic [OFFSET_BITS-1:0] vf;
    logic [OFFSET_BITS-1:0] dist_lo;
    logic [OFFSET_BITS-1:0] klen_lo;
    logic [OFFSET_BITS-1:0] vlen_lo;
    logic [WIDE-1:0]        dist_ext;
    logic [WIDE-1:0]        max_ext;
    logic [WIDE-1:0]        ks_ext;
    logic [WIDE-1:0]        kl_ext;
    logic [WIDE-1:0]        vs_ext;
    logic [WIDE-1:0]        vl_ext;
    logic                   err;
    logic                   pair;

    always_comb
    begin
        // A new block starts from cleared state at offset zero
        ph  = new_block ? PH_START : phase;
        off = new_block ? '0 : offset;
        kb  = new_block ? '0 : key_begin;
        kf  = new_block ? '0 : key_finish;
        vb  = new_block ? '0 : value_begin;
        vf  = new_block ? '0 : value_finish;

        off_lo   = off[OFFSET_BITS-1:0];
        dist_lo  = off_lo - vb;
        dist_ext = {16'b0, dist_lo};
        max_ext  = {{OFFSET_BITS{1'b0}}, max_value_len};

        // Saturate one past the last representable offset
        offset_next = off[OFFSET_BITS] ? off : off + {{OFFSET_BITS{1'b0}}, 1'b1};

        ctl.phase         = ph;
        ctl.ev            = EV_NONE;
        key_begin_next    = kb;
        key_finish_next   = kf;
        value_begin_next  = vb;
        value_finish_next = vf;
        err               = 1'b0;
        pair              = 1'b0;

        if (ph >= PH_DONE)
        begin
            // done and error hold until the next block
            ctl.phase = ph;
        end
        else if (off[OFFSET_BITS])
        begin
            err = 1'b1;
        end
        else
        begin
            case (ph)
                PH_START:
                begin
                    if (hdr_byte == CH_COLON)
                        err = 1'b1;
                    else if (hdr_byte != CH_CR && hdr_byte != CH_LF)
                    begin
                        key_begin_next = off_lo;
                        ctl.phase      = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    if (hdr_byte == CH_COLON)
                    begin
                        key_finish_next = off_lo;
                        ctl.phase       = PH_COLON;
                    end
                    else if (hdr_byte == CH_CR || hdr_byte == CH_LF)
                        err = 1'b1;
                end
                PH_COLON:
                begin
                    if (hdr_byte == CH_SPACE)
                        ctl.phase = PH_SPACE;
                    else
                        err = 1'b1;
                end
                PH_SPACE:
                begin
                    if (hdr_byte == CH_CR)
                        err = 1'b1;
                    else
                    begin
                        value_begin_next = off_lo;
                        ctl.phase        = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (hdr_byte == CH_CR)
                    begin
                        value_finish_next = off_lo;
                        ctl.phase         = PH_CR;
                    end
                    else if (dist_ext > max_ext)
                        err = 1'b1;
                end
                PH_CR:
                begin
                    if (hdr_byte == CH_LF)
                    begin
                        ctl.phase = PH_LF;
                        ctl.ev    = EV_PAIR;
                        pair      = 1'b1;
                    end
                    else
                        err = 1'b1;
                end
                PH_LF:
                begin
                    if (hdr_byte == CH_CR)
                        ctl.phase = PH_ENDCR;
                    else if (hdr_byte == CH_LF || hdr_byte == CH_COLON)
                        err = 1'b1;
                    else
                    begin
                        key_begin_next = off_lo;
                        ctl.phase      = PH_KEY;
                    end
                end
                PH_ENDCR:
                begin
                    if (hdr_byte == CH_LF)
                    begin
                        ctl.phase = PH_DONE;
                        ctl.ev    = EV_DONE;
                    end
                    else
                        err = 1'b1;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        if (err)
        begin
            ctl.phase = PH_ERROR;
            ctl.ev    = EV_ERROR;
            pair      = 1'b0;
        end

        // Positions go out as 16-bit fields, zero unless a pair completes
        klen_lo = kf - kb;
        vlen_lo = vf - vb;
        ks_ext  = {16'b0, kb};
        kl_ext  = {16'b0, klen_lo};
        vs_ext  = {16'b0, vb};
        vl_ext  = {16'b0, vlen_lo};

        key_pos   = pair ? ks_ext[15:0] : 16'd0;
        key_len   = pair ? kl_ext[15:0] : 16'd0;
        value_pos = pair ? vs_ext[15:0] : 16'd0;
        value_len = pair ? vl_ext[15:0] : 16'd0;
    end

endmodule

/* tb/tb_http_header_field_tokenizer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_header_field_tokenizer: a scripted opening and
// random header blocks under several max_value_len settings.
// Depends on hhft_pkg and the tokenizer RTL.
module tb_http_header_field_tokenizer;
    import hhft_pkg::*;

    localparam int          CLK_HALF    = 2;
    localparam int          RST_CYCLES  = 8;
    // Watchdog limit on cycles with no beat moving; the longest legal quiet spell, the
    // longest sender gap or sink stall plus the pipeline, stays well below it.
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          PHASE_BEATS = 270;
    localparam logic [16:0] POS_MAX     = 17'h0FFFF;

    // One result beat, fields in the order they are compared.
    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] key_pos;
        logic [15:0] key_len;
        logic [15:0] value_pos;
        logic [15:0] value_len;
    } hdr_event_t;

    // Opening script: byte, new-block flag, and whether the expected event is
    // typed in here (position fields then all zero) or left to the model.
    typedef struct packed {
        logic [7:0] hdr;
        logic       fresh;
        logic       fixed;
        logic [1:0] ev;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] hdr_byte
    logic [0:0]  s_axis_tuser;    // [0] new_block
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // [15:0] key_pos, [31:16] key_len,
                                  // [47:32] value_pos, [63:48] value_len
    logic [1:0]  m_axis_tuser;    // [1:0] event_res

    // Tokenizer model state: phase, saturating position counter, field bounds.
    logic [3:0]  tok_phase = PH_START;
    logic [16:0] tok_pos   = '0;
    logic [15:0] key_at    = '0;
    logic [15:0] key_end   = '0;
    logic [15:0] val_at    = '0;
    logic [15:0] val_end   = '0;
    logic [15:0] val_limit = MAX_VALUE_LEN_RST;

    hdr_event_t  pending_events [$];
    script_row_t script [$];
    hdr_event_t  due;
    hdr_event_t  seen;

    int          mismatches  = 0;
    int          live_beats  = 0;
    int          idle_cycles = 0;
    int          src_quiet   = 0;
    int          sink_quiet  = 0;
    int          sink_hold   = 0;
    int          sink_roll;
    bit          no_idle     = 1'b0;
    bit          block_start;
    bit          corrupt;

    always #(CLK_HALF) clk = ~clk;

    http_header_field_tokenizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Advance the model by one accepted byte and return the result it owes.
    function automatic hdr_event_t tokenize_byte(input logic [7:0] b, input logic fresh);
        hdr_event_t  r;
        logic [16:0] at;
        logic        err;
        r   = '0;
        err = 1'b0;
        if (fresh)
        begin
            tok_phase = PH_START;
            tok_pos   = '0;
            key_at    = '0;
            key_end   = '0;
            val_at    = '0;
            val_end   = '0;
        end
        at = tok_pos;
        if (tok_pos <= POS_MAX)
            tok_pos = tok_pos + 17'd1;
        // done and error hold silently; only the position keeps counting
        if (tok_phase >= PH_DONE)
            return r;
        if (at > POS_MAX)
            err = 1'b1;
        else
        begin
            case (tok_phase)
                PH_START:
                    if (b == CH_COLON)
                        err = 1'b1;
                    else if (b != CH_CR && b != CH_LF)
                    begin
                        key_at    = at[15:0];
                        tok_phase = PH_KEY;
                    end
                PH_KEY:
                    if (b == CH_COLON)
                    begin
                        key_end   = at[15:0];
                        tok_phase = PH_COLON;
                    end
                    else if (b == CH_CR || b == CH_LF)
                        err = 1'b1;
                PH_COLON:
                    if (b == CH_SPACE)
                        tok_phase = PH_SPACE;
                    else
                        err = 1'b1;
                PH_SPACE:
                    if (b == CH_CR)
                        err = 1'b1;
                    else
                    begin
                        val_at    = at[15:0];
                        tok_phase = PH_VALUE;
                    end
                PH_VALUE:
                    if (b == CH_CR)
                    begin
                        val_end   = at[15:0];
                        tok_phase = PH_CR;
                    end
                    else if (at - {1'b0, val_at} > {1'b0, val_limit})
                        err = 1'b1;
                PH_CR:
                    if (b == CH_LF)
                    begin
                        tok_phase   = PH_LF;
                        r.ev        = EV_PAIR;
                        r.key_pos   = key_at;
                        r.key_len   = key_end - key_at;
                        r.value_pos = val_at;
                        r.value_len = val_end - val_at;
                    end
                    else
                        err = 1'b1;
                PH_LF:
                    if (b == CH_CR)
                        tok_phase = PH_ENDCR;
                    else if (b == CH_LF || b == CH_COLON)
                        err = 1'b1;
                    else
                    begin
                        key_at    = at[15:0];
                        tok_phase = PH_KEY;
                    end
                PH_ENDCR:
                    if (b == CH_LF)
                    begin
                        tok_phase = PH_DONE;
                        r.ev      = EV_DONE;
                    end
                    else
                        err = 1'b1;
                default:
                    err = 1'b1;
            endcase
        end
        if (err)
        begin
            tok_phase = PH_ERROR;
            r         = '0;
            r.ev      = EV_ERROR;
        end
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, now and then a clean run.
    function automatic int src_gap();
        int r;
        if (no_idle)
            return 0;
        if (src_quiet > 0)
        begin
            src_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            src_quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] key_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || b == CH_COLON);
        return b;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR);
        return b;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Present one byte after a random gap, hold it until the handshake, then log
    // the result the model expects for it.
    task automatic push_byte(input logic [7:0] hdr, input logic fresh,
                             input logic fixed, input logic [1:0] fixed_ev);
        int         gap;
        hdr_event_t want;
        gap = src_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hdr;
        s_axis_tuser  <= fresh;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // bytes swallowed by a held done or error phase do not count as work
        if (fresh || tok_phase < PH_DONE)
            live_beats++;
        want = tokenize_byte(hdr, fresh);
        if (fixed)
        begin
            want    = '0;
            want.ev = fixed_ev;
        end
        pending_events.push_back(want);
    endtask

    // Send one byte of a random block: flag the first byte as a new block, and in
    // a corrupted block sometimes swap in a delimiter or junk, or restart early.
    task automatic feed(input logic [7:0] hdr);
        logic [7:0] b;
        logic       nb;
        b  = hdr;
        nb = block_start;
        if (corrupt && $urandom_range(0, 24) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       b = CH_CR;
                1:       b = CH_LF;
                2:       b = CH_COLON;
                3:       b = CH_SPACE;
                default: b = 8'($urandom_range(0, 255));
            endcase
        end
        if (corrupt && !block_start && $urandom_range(0, 199) == 0)
            nb = 1'b1;
        block_start = 1'b0;
        push_byte(b, nb, 1'b0, EV_NONE);
    endtask

    // A header block: optional leading CR/LF, zero to four "key: value" lines,
    // closing blank line; a quarter of the blocks may get damaged on the way.
    task automatic send_random_block();
        block_start = 1'b1;
        corrupt     = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2))
            feed(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        repeat ($urandom_range(0, 4))
        begin
            repeat ($urandom_range(1, 8))
                feed(key_byte());
            feed(CH_COLON);
            feed(CH_SPACE);
            repeat ($urandom_range(1, 12))
                feed(value_byte());
            feed(CH_CR);
            feed(CH_LF);
        end
        feed(CH_CR);
        feed(CH_LF);
        // trailing junk lands on a held phase or keeps a broken block going
        if (corrupt)
            repeat ($urandom_range(0, 3))
                feed(8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int beats);
        int stop_at;
        stop_at = live_beats + beats;
        while (live_beats < stop_at)
            send_random_block();
    endtask

    // Drop valid and hold until every owed result has come back, plus a margin
    // for the two pipeline stages.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_value_limit(input logic [15:0] lim);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        val_limit = lim;
    endtask

    // Sink side: random stalls of mixed length, with occasional stall-free runs.
    always @(posedge clk)
    begin
        if (no_idle || sink_quiet > 0)
        begin
            if (sink_quiet > 0)
                sink_quiet--;
            m_axis_tready <= 1'b1;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 3)
                sink_quiet = $urandom_range(20, 80);
            else if (sink_roll < 20)
                sink_hold = $urandom_range(1, 3);
            else if (sink_roll < 25)
                sink_hold = $urandom_range(4, 12);
            else if (sink_roll < 27)
                sink_hold = $urandom_range(20, 80);
        end
    end

    // Result checker: every result beat must match the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                    m_axis_tdata[47:32], m_axis_tdata[63:48]};
            if (pending_events.size() == 0)
            begin
                $display("%0t ns: unexpected result beat, expected none, got %h",
                         $time, seen);
                mismatches++;
            end
            else
            begin
                due = pending_events.pop_front();
                check_field("event_res", {14'd0, due.ev}, {14'd0, seen.ev});
                check_field("key_pos", due.key_pos, seen.key_pos);
                check_field("key_len", due.key_len, seen.key_len);
                check_field("value_pos", due.value_pos, seen.value_pos);
                check_field("value_len", due.value_len, seen.value_len);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // colon where a key must begin, then a held error phase
        script.push_back('{CH_COLON, 1'b1, 1'b1, EV_ERROR});
        script.push_back('{8'hFF,    1'b0, 1'b1, EV_NONE});
        // new block: skip leading CR LF, one pair with extreme bytes, blank line
        script.push_back('{CH_CR,    1'b1, 1'b1, EV_NONE});
        script.push_back('{CH_LF,    1'b0, 1'b1, EV_NONE});
        script.push_back('{8'h00,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_COLON, 1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_SPACE, 1'b0, 1'b0, EV_NONE});
        script.push_back('{8'hFF,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_CR,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_LF,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_CR,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_LF,    1'b0, 1'b1, EV_DONE});
        script.push_back('{8'h41,    1'b0, 1'b1, EV_NONE});
        // bare LF inside a key
        script.push_back('{8'h6B,    1'b1, 1'b0, EV_NONE});
        script.push_back('{CH_LF,    1'b0, 1'b1, EV_ERROR});
        // no space after the colon
        script.push_back('{8'h6B,    1'b1, 1'b0, EV_NONE});
        script.push_back('{CH_COLON, 1'b0, 1'b0, EV_NONE});
        script.push_back('{8'h78,    1'b0, 1'b1, EV_ERROR});
        // empty value
        script.push_back('{8'h6B,    1'b1, 1'b0, EV_NONE});
        script.push_back('{CH_COLON, 1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_SPACE, 1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_CR,    1'b0, 1'b1, EV_ERROR});
        // stray byte where the LF after a value's CR belongs
        script.push_back('{8'h6B,    1'b1, 1'b0, EV_NONE});
        script.push_back('{CH_COLON, 1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_SPACE, 1'b0, 1'b0, EV_NONE});
        script.push_back('{8'h76,    1'b0, 1'b0, EV_NONE});
        script.push_back('{CH_CR,    1'b0, 1'b0, EV_NONE});
        script.push_back('{8'h7A,    1'b0, 1'b1, EV_ERROR});
        foreach (script[i])
            push_byte(script[i].hdr, script[i].fresh, script[i].fixed, script[i].ev);

        // random blocks under the reset limit, then the smallest limit, small and
        // random ones, and the largest; each write waits for the pipe to drain
        run_random(PHASE_BEATS);
        set_value_limit(16'd1);
        run_random(PHASE_BEATS);
        set_value_limit(16'd4);
        run_random(PHASE_BEATS);
        set_value_limit(16'd16);
        run_random(PHASE_BEATS);
        set_value_limit(16'($urandom_range(1, 65535)));
        run_random(PHASE_BEATS);
        set_value_limit(16'hFFFF);
        // last phase runs with both sides free: back-to-back beats throughout
        no_idle = 1'b1;
        run_random(PHASE_BEATS);
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
